FILE: rtl/core/stq_pkg.sv
`default_nettype none

package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int DELAY_W     = 16;
	localparam int FRAC_W      = 20;
	localparam int CB_W        = 8;
	localparam int HANDLE_W    = 4;
	localparam int OUT_TAG_W   = 32;

	typedef enum logic [1:0] {
		KIND_SCHEDULE = 2'd0,
		KIND_CANCEL   = 2'd1,
		KIND_TICK     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STAT_SCHEDULED    = 3'd0,
		STAT_REJ_FRACTION = 3'd1,
		STAT_REJ_FULL     = 3'd2,
		STAT_CANCELLED    = 3'd3,
		STAT_FIRED        = 3'd4,
		STAT_SUMMARY      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCH_ADD,
		S_SCH_WALK,
		S_CAN_CHK,
		S_CAN_WALK,
		S_TICK_INC,
		S_TICK_CHK,
		S_TICK_SUM,
		S_EMIT
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic [CB_W-1:0]       cb;
		logic [OUT_TAG_W-1:0]  tag;
		logic                  next_valid;
		logic [DELAY_W-1:0]    next_delay;
		logic                  last;
	} result_t;

	// insert puts slot at pos and shifts the tail up; remove drops pos and frees slot
	typedef struct packed {
		logic             ins;
		logic             rm;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] slot;
	} store_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             free_any;
		logic [IDX_W-1:0] free_slot;
	} store_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/stq_alu.sv
`default_nettype none

module stq_alu
	import stq_pkg::*;
(
	input  wire alu_op_t           op,
	input  wire logic [TIME_W-1:0] a,
	input  wire logic [TIME_W-1:0] b,
	output logic [TIME_W-1:0]      res,
	output logic                   carry
);

	logic [TIME_W-1:0] b_eff;
	logic [TIME_W:0]   sum;

	// on subtract, carry set means a >= b
	assign b_eff = (op == ALU_SUB) ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_eff} + (TIME_W + 1)'(op == ALU_SUB);
	assign res   = sum[TIME_W-1:0];
	assign carry = sum[TIME_W];

endmodule

`default_nettype wire

FILE: rtl/core/stq_store.sv
`default_nettype none

module stq_store
	import stq_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire store_cmd_t             cmd,
	input  wire logic [TIME_W-1:0]      wr_expiry,
	input  wire logic [CB_W-1:0]        wr_callback,
	input  wire logic [TAG_BITS-1:0]    wr_tag,
	input  wire logic [IDX_W-1:0]       rd_pos,
	output logic [IDX_W-1:0]            rd_slot,
	output logic [TIME_W-1:0]           rd_expiry,
	output logic [CB_W-1:0]             rd_callback,
	output logic [TAG_BITS-1:0]         rd_tag,
	output logic [QUEUE_DEPTH-1:0]      in_use,
	output store_stat_t                 stat
);

	logic [TIME_W-1:0]   expiry_q [QUEUE_DEPTH];
	logic [CB_W-1:0]     callback_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] tag_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]    order_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] in_use_q;
	logic [CNT_W-1:0]    count_q;

	assign rd_slot     = order_q[rd_pos];
	assign rd_expiry   = expiry_q[rd_slot];
	assign rd_callback = callback_q[rd_slot];
	assign rd_tag      = tag_q[rd_slot];
	assign in_use      = in_use_q;

	always_comb begin
		stat.count     = count_q;
		stat.free_any  = ~&in_use_q;
		stat.free_slot = '0;
		// lowest free slot wins
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!in_use_q[IDX_W'(i)]) begin
				stat.free_slot = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			count_q  <= '0;
		end else if (cmd.ins) begin
			in_use_q[cmd.slot] <= 1'b1;
			count_q            <= count_q + CNT_W'(1);
		end else if (cmd.rm) begin
			in_use_q[cmd.slot] <= 1'b0;
			count_q            <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			expiry_q[cmd.slot]   <= wr_expiry;
			callback_q[cmd.slot] <= wr_callback;
			tag_q[cmd.slot]      <= wr_tag;
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.ins) begin
				if (IDX_W'(i) == cmd.pos) begin
					order_q[IDX_W'(i)] <= cmd.slot;
				end else if (IDX_W'(i) > cmd.pos) begin
					order_q[IDX_W'(i)] <= order_q[IDX_W'(i - 1)];
				end
			end else if (cmd.rm) begin
				if (IDX_W'(i) >= cmd.pos && i < QUEUE_DEPTH - 1) begin
					order_q[IDX_W'(i)] <= order_q[IDX_W'(i + 1)];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_timer_event_queue_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  kind, delay_seconds, delay_fraction_us, callback_id,
//                               data_tag, cancel_handle
// out      out_valid / out_stall status, handle, fired_callback, fired_tag, next_valid,
//                               next_delay_seconds, last
//
// One transaction is worked at a time; in_stall is high from acceptance until the last
// result has been loaded into the output register.
// Steps from one acceptance to the next, with the output free:
// Schedule: add, a walk along the list to the insertion point, then emit.
// Cancel: check, a walk to the slot's position when the slot is live, then emit.
// Tick: increment, check, emit per fired event; summary step if entries remain; emit.
// Time compares and adds go through one 32-bit add/subtract unit; the walk sets the time.
// arst_n clears the uptime, the slot use bits and the entry count.
// A stalled output holds its result; the sequencer waits in its emit step meanwhile.
`default_nettype none

module sorted_timer_event_queue_core
	import stq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic [DELAY_W-1:0]   delay_seconds,
	input  wire logic [FRAC_W-1:0]    delay_fraction_us,
	input  wire logic [CB_W-1:0]      callback_id,
	input  wire logic [OUT_TAG_W-1:0] data_tag,
	input  wire logic [HANDLE_W-1:0]  cancel_handle,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                status,
	output logic [HANDLE_W-1:0]       handle,
	output logic [CB_W-1:0]           fired_callback,
	output logic [OUT_TAG_W-1:0]      fired_tag,
	output logic                      next_valid,
	output logic [DELAY_W-1:0]        next_delay_seconds,
	output logic                      last
);

	state_t               state_q, state_d, ret_q, ret_d;
	result_t              res_q, res_d, res_new, out_q;
	logic                 out_valid_q, out_free, out_load;
	logic [CNT_W-1:0]     ptr_q, ptr_d;
	logic [TIME_W-1:0]    exp_q, exp_d, uptime_q, uptime_d;
	logic [IDX_W-1:0]     slot_q, slot_d, h_idx;
	logic [DELAY_W-1:0]   delay_q;
	logic [CB_W-1:0]      cb_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic                 h_ok, accept;

	alu_op_t              alu_op;
	logic [TIME_W-1:0]    alu_a, alu_b, alu_res;
	logic                 alu_carry;

	store_cmd_t           cmd;
	store_stat_t          stat;
	logic [IDX_W-1:0]     rd_pos, rd_slot;
	logic [TIME_W-1:0]    rd_expiry;
	logic [CB_W-1:0]      rd_callback;
	logic [TAG_BITS-1:0]  rd_tag;
	logic [QUEUE_DEPTH-1:0] in_use;

	stq_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry)
	);

	stq_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_expiry   (exp_q),
		.wr_callback (cb_q),
		.wr_tag      (tag_q),
		.rd_pos      (rd_pos),
		.rd_slot     (rd_slot),
		.rd_expiry   (rd_expiry),
		.rd_callback (rd_callback),
		.rd_tag      (rd_tag),
		.in_use      (in_use),
		.stat        (stat)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign h_ok     = 32'(handle_q) < QUEUE_DEPTH;
	assign h_idx    = IDX_W'(handle_q);

	assign out_valid          = out_valid_q;
	assign status             = out_q.status;
	assign handle             = out_q.handle;
	assign fired_callback     = out_q.cb;
	assign fired_tag          = out_q.tag;
	assign next_valid         = out_q.next_valid;
	assign next_delay_seconds = out_q.next_delay;
	assign last               = out_q.last;

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		res_d    = res_q;
		res_new  = '0;
		ptr_d    = ptr_q;
		exp_d    = exp_q;
		uptime_d = uptime_q;
		slot_d   = slot_q;
		cmd      = '0;
		rd_pos   = ptr_q[IDX_W-1:0];
		alu_op   = ALU_SUB;
		alu_a    = uptime_q;
		alu_b    = rd_expiry;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						KIND_SCHEDULE: begin
							if (delay_fraction_us != '0) begin
								res_new.status = STAT_REJ_FRACTION;
								res_new.last   = 1'b1;
								res_d          = res_new;
								ret_d          = S_IDLE;
								state_d        = S_EMIT;
							end else if (!stat.free_any) begin
								res_new.status = STAT_REJ_FULL;
								res_new.last   = 1'b1;
								res_d          = res_new;
								ret_d          = S_IDLE;
								state_d        = S_EMIT;
							end else begin
								slot_d  = stat.free_slot;
								state_d = S_SCH_ADD;
							end
						end
						KIND_CANCEL: state_d = S_CAN_CHK;
						KIND_TICK:   state_d = S_TICK_INC;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_SCH_ADD: begin
				alu_op  = ALU_ADD;
				alu_a   = uptime_q;
				alu_b   = TIME_W'(delay_q);
				exp_d   = alu_carry ? '1 : alu_res;
				ptr_d   = '0;
				state_d = S_SCH_WALK;
			end
			S_SCH_WALK: begin
				alu_a = exp_q;
				alu_b = rd_expiry;
				// goes ahead of the first entry that expires strictly later
				if (ptr_q == stat.count || !alu_carry) begin
					cmd.ins        = 1'b1;
					cmd.pos        = ptr_q[IDX_W-1:0];
					cmd.slot       = slot_q;
					res_new.status = STAT_SCHEDULED;
					res_new.handle = HANDLE_W'(slot_q);
					res_new.last   = 1'b1;
					res_d          = res_new;
					ret_d          = S_IDLE;
					state_d        = S_EMIT;
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			S_CAN_CHK: begin
				res_new.status = STAT_CANCELLED;
				res_new.handle = handle_q;
				res_new.last   = 1'b1;
				if (h_ok && in_use[h_idx]) begin
					ptr_d   = '0;
					state_d = S_CAN_WALK;
				end else begin
					res_d   = res_new;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end
			end
			S_CAN_WALK: begin
				res_new.status = STAT_CANCELLED;
				res_new.handle = handle_q;
				res_new.last   = 1'b1;
				if (ptr_q == stat.count) begin
					res_d   = res_new;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end else if (rd_slot == h_idx) begin
					cmd.rm   = 1'b1;
					cmd.pos  = ptr_q[IDX_W-1:0];
					cmd.slot = h_idx;
					res_d    = res_new;
					ret_d    = S_IDLE;
					state_d  = S_EMIT;
				end else begin
					ptr_d = ptr_q + CNT_W'(1);
				end
			end
			S_TICK_INC: begin
				alu_op = ALU_ADD;
				alu_a  = uptime_q;
				alu_b  = TIME_W'(1);
				if (!alu_carry) begin
					uptime_d = alu_res;
				end
				state_d = S_TICK_CHK;
			end
			S_TICK_CHK: begin
				rd_pos = '0;
				alu_a  = uptime_q;
				alu_b  = rd_expiry;
				if (stat.count == '0) begin
					res_new.status = STAT_SUMMARY;
					res_new.last   = 1'b1;
					res_d          = res_new;
					ret_d          = S_IDLE;
					state_d        = S_EMIT;
				end else if (alu_carry) begin
					// head is due: fire it and come back for the next one
					res_new.status = STAT_FIRED;
					res_new.handle = HANDLE_W'(rd_slot);
					res_new.cb     = rd_callback;
					res_new.tag    = OUT_TAG_W'(rd_tag);
					res_d          = res_new;
					cmd.rm         = 1'b1;
					cmd.pos        = '0;
					cmd.slot       = rd_slot;
					ret_d          = S_TICK_CHK;
					state_d        = S_EMIT;
				end else begin
					state_d = S_TICK_SUM;
				end
			end
			S_TICK_SUM: begin
				rd_pos             = '0;
				alu_a              = rd_expiry;
				alu_b              = uptime_q;
				res_new.status     = STAT_SUMMARY;
				res_new.next_valid = 1'b1;
				res_new.next_delay = (alu_res[TIME_W-1:DELAY_W] != '0) ? '1
					: alu_res[DELAY_W-1:0];
				res_new.last       = 1'b1;
				res_d              = res_new;
				ret_d              = S_IDLE;
				state_d            = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			ptr_q       <= '0;
			uptime_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			ptr_q    <= ptr_d;
			uptime_q <= uptime_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		exp_q  <= exp_d;
		slot_q <= slot_d;
		if (out_load) begin
			out_q <= res_q;
		end
		if (accept) begin
			delay_q  <= delay_seconds;
			cb_q     <= callback_id;
			tag_q    <= TAG_BITS'(data_tag);
			handle_q <= cancel_handle;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/stq_checker.sv
`default_nettype none

module stq_checker
	import stq_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [1:0]           kind,
	input wire logic [DELAY_W-1:0]   delay_seconds,
	input wire logic [FRAC_W-1:0]    delay_fraction_us,
	input wire logic [CB_W-1:0]      callback_id,
	input wire logic [OUT_TAG_W-1:0] data_tag,
	input wire logic [HANDLE_W-1:0]  cancel_handle,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [2:0]           status,
	input wire logic [HANDLE_W-1:0]  handle,
	input wire logic [CB_W-1:0]      fired_callback,
	input wire logic [OUT_TAG_W-1:0] fired_tag,
	input wire logic                 next_valid,
	input wire logic [DELAY_W-1:0]   next_delay_seconds,
	input wire logic                 last
);

	// an accepted transaction of a defined kind always keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall
		&& (kind == KIND_SCHEDULE || kind == KIND_CANCEL || kind == KIND_TICK)
		|=> in_stall)
		else $error("block not busy after accepting a transaction");

	// only fired events leave the sequence open
	a_last_vs_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == STAT_FIRED) == !last))
		else $error("last flag does not match result kind");

	a_summary_delay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_SUMMARY && next_valid |-> next_delay_seconds != '0)
		else $error("summary reports zero delay to next expiry");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(handle)
		&& $stable(fired_tag) && $stable(last))
		else $error("stalled result changed");

endmodule

bind sorted_timer_event_queue_core stq_checker u_stq_checker (.*);

`default_nettype wire
